/* rtl/pnc_pkg.sv */
// Package for the palette nearest-colour search core.
// Holds shared types, widths, constants and the light-scaling function.
// Depends on nothing.
`timescale 1ns / 1ps

package pnc_pkg;

  localparam int ENTRY_COUNT_DEF = 256;
  localparam int CHAN_W          = 8;
  localparam int LEVEL_W         = 7;
  localparam int DIFF_W          = 13;
  localparam int SQ_W            = 24;
  localparam int SCORE_W         = 24;
  localparam int LEVEL_SHIFT     = 6;

  localparam logic [SCORE_W-1:0] COLOUR_BOUND = SCORE_W'(9999999);
  localparam logic [SCORE_W-1:0] LIT_BOUND    = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LIT    = 2'd1,
    OP_COLOUR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_SEARCH,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  // Scales one channel by level/64 and clamps it to 255.
  function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] v,
                                                      input logic [LEVEL_W-1:0] level);
    logic [CHAN_W+LEVEL_W-1:0] prod;
    logic [CHAN_W+LEVEL_W-LEVEL_SHIFT-1:0] s;
    prod = {{LEVEL_W{1'b0}}, v} * {{CHAN_W{1'b0}}, level};
    s = prod[CHAN_W+LEVEL_W-1:LEVEL_SHIFT];
    if (s[CHAN_W+LEVEL_W-LEVEL_SHIFT-1:CHAN_W] != '0) begin
      return '1;
    end
    return s[CHAN_W-1:0];
  endfunction

endpackage

/* rtl/pnc_cell.sv */
// One palette entry in the rotating ring of cells.
// Depends on pnc_pkg for the colour type.
`timescale 1ns / 1ps

module pnc_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  pnc_pkg::colour_t d,
  output pnc_pkg::colour_t q
);
  import pnc_pkg::*;

  colour_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule

/* rtl/pnc_dist.sv */
// Three-stage weighted distance pipeline shared by both lookup kinds.
// Depends on pnc_pkg for widths and the colour type.
`timescale 1ns / 1ps

module pnc_dist #(
  parameter int IDXW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IDXW-1:0]              in_idx,
  input  pnc_pkg::colour_t             entry,
  input  pnc_pkg::colour_t             target,
  input  logic                         add_sum,
  output logic                         out_valid,
  output logic [IDXW-1:0]              out_idx,
  output logic [pnc_pkg::SCORE_W-1:0]  out_score,
  output logic                         pipe_busy
);
  import pnc_pkg::*;

  logic                     v1, v2;
  logic [IDXW-1:0]          idx1, idx2;
  logic signed [DIFF_W-1:0] db, dg, dr, ds;
  logic [SQ_W-1:0]          sqb, sqg, sqr, sqs;
  logic signed [DIFF_W-1:0] db_c, dg_c, dr_c;

  always_comb begin
    db_c = DIFF_W'(signed'({1'b0, entry.blue}))  - DIFF_W'(signed'({1'b0, target.blue}));
    dg_c = DIFF_W'(signed'({1'b0, entry.green})) - DIFF_W'(signed'({1'b0, target.green}));
    dr_c = DIFF_W'(signed'({1'b0, entry.red}))   - DIFF_W'(signed'({1'b0, target.red}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Weights 4, 5 and 3 are shift-and-add.
  always_ff @(posedge clk) begin
    idx1 <= in_idx;
    db   <= db_c <<< 2;
    dg   <= (dg_c <<< 2) + dg_c;
    dr   <= (dr_c <<< 1) + dr_c;
    ds   <= (db_c <<< 2) + (dg_c <<< 2) + dg_c + (dr_c <<< 1) + dr_c;
  end

  // The differences are sign-extended to the full square width before the
  // multiply, so that no square loses its upper bits.
  always_ff @(posedge clk) begin
    idx2 <= idx1;
    sqb  <= unsigned'(SQ_W'(db) * SQ_W'(db));
    sqg  <= unsigned'(SQ_W'(dg) * SQ_W'(dg));
    sqr  <= unsigned'(SQ_W'(dr) * SQ_W'(dr));
    sqs  <= add_sum ? unsigned'(SQ_W'(ds) * SQ_W'(ds)) : '0;
  end

  always_ff @(posedge clk) begin
    out_idx   <= idx2;
    out_score <= sqb + sqg + sqr + sqs;
  end

  assign pipe_busy = v1 | v2 | out_valid;

endmodule

/* rtl/palette_nearest_colour_search_core.sv */
// Top level of the palette nearest-colour search core.
// Depends on pnc_pkg, pnc_cell and pnc_dist.
`timescale 1ns / 1ps

// The palette lives in a ring of ENTRY_COUNT cells that rotates by one entry
// per cycle while a request loads, fetches or searches, so every lookup walks
// the whole palette past one shared distance unit. A request is taken when
// start is high and busy is low. A load walks the ring once and gives no result.
// A colour lookup searches one turn of the ring and then lets the distance
// pipeline drain, and its result appears in the same cycle as busy falls; a
// lit lookup first spends a further turn of the ring to fetch and scale the
// addressed entry. Each lookup result appears on nearest_entry for exactly
// one cycle with done high; the receiver cannot stall it, so it must take the
// result in that cycle. An unused opcode is dropped without a result.
module palette_nearest_colour_search_core #(
  parameter int ENTRY_COUNT = pnc_pkg::ENTRY_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] entry_index,
  input  logic [6:0] light_level,
  input  logic [7:0] blue_value,
  input  logic [7:0] green_value,
  input  logic [7:0] red_value,
  output logic       done,
  output logic [7:0] nearest_entry
);
  import pnc_pkg::*;

  localparam int IDXW = $clog2(ENTRY_COUNT);
  localparam logic [IDXW-1:0] LAST = IDXW'(ENTRY_COUNT - 1);

  state_t state, state_next;

  logic [IDXW-1:0]    cnt;
  logic [7:0]         req_index;
  logic [LEVEL_W-1:0] req_level;
  colour_t            req_colour;
  logic               req_is_colour;
  logic               req_in_range;
  colour_t            target;
  logic [SCORE_W-1:0] best;
  logic [IDXW-1:0]    pick;

  logic    accept, rotate, feed, finish, at_entry, last_step;
  colour_t ring [ENTRY_COUNT];
  colour_t head, tail_in;

  logic               d_valid, d_busy;
  logic [IDXW-1:0]    d_idx;
  logic [SCORE_W-1:0] d_score;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign head      = ring[0];
  assign last_step = (cnt == LAST);
  assign at_entry  = req_in_range && (cnt == req_index[IDXW-1:0]);

  // The ring: cell i takes its neighbour's entry, the last cell takes the
  // head back (or the new entry when a load reaches its slot).
  for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_ring
    colour_t d_in;
    if (i == ENTRY_COUNT - 1) begin : g_tail
      assign d_in = tail_in;
    end else begin : g_mid
      assign d_in = ring[i+1];
    end
    pnc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (rotate),
      .d     (d_in),
      .q     (ring[i])
    );
  end

  // Entry 0 is always black, so a load to it stores zero.
  always_comb begin
    tail_in = head;
    if (state == S_LOAD && at_entry) begin
      tail_in = (req_index == '0) ? '0 : req_colour;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_LOAD:   state_next = S_LOAD;
            OP_LIT:    state_next = S_FETCH;
            OP_COLOUR: state_next = S_SEARCH;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD:   if (last_step) state_next = S_IDLE;
      S_FETCH:  if (last_step) state_next = S_SEARCH;
      S_SEARCH: if (last_step) state_next = S_DRAIN;
      S_DRAIN:  if (!d_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rotate = 1'b0;
    feed   = 1'b0;
    finish = 1'b0;
    case (state)
      S_LOAD, S_FETCH: rotate = 1'b1;
      S_SEARCH: begin
        rotate = 1'b1;
        // Entry 0 never takes part in a search.
        feed   = (cnt != '0);
      end
      S_DRAIN: finish = !d_busy;
      default: begin
        rotate = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (accept) begin
        cnt <= '0;
      end else if (rotate) begin
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
    end
  end

  // Request fields, target colour and the running minimum.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_index     <= entry_index;
      req_level     <= light_level;
      req_colour    <= '{red: red_value, green: green_value, blue: blue_value};
      req_is_colour <= (op_t'(opcode) == OP_COLOUR);
      req_in_range  <= ({1'b0, entry_index} < 9'(ENTRY_COUNT));
      best          <= (op_t'(opcode) == OP_COLOUR) ? COLOUR_BOUND : LIT_BOUND;
      pick          <= '0;
      if (op_t'(opcode) == OP_COLOUR) begin
        target <= '{red: red_value, green: green_value, blue: blue_value};
      end else begin
        // A lit lookup beyond the palette scales black.
        target <= '0;
      end
    end else begin
      if (state == S_FETCH && at_entry) begin
        target.blue  <= scale_channel(head.blue, req_level);
        target.green <= scale_channel(head.green, req_level);
        target.red   <= scale_channel(head.red, req_level);
      end
      // Strictly less, so the lowest-numbered minimum is kept.
      if (d_valid && d_score < best) begin
        best <= d_score;
        pick <= d_idx;
      end
    end
    if (finish) begin
      nearest_entry <= 8'(pick);
    end
  end

  pnc_dist #(
    .IDXW (IDXW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (feed),
    .in_idx    (cnt),
    .entry     (head),
    .target    (target),
    .add_sum   (req_is_colour),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .out_score (d_score),
    .pipe_busy (d_busy)
  );

endmodule

/* rtl/pnc_checker.sv */
// Port-level checker for the palette nearest-colour search core, and its bind.
// Depends on the top level's ports and on pnc_pkg for the opcode names.
`timescale 1ns / 1ps

module pnc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       done,
  input logic [7:0] nearest_entry
);
  import pnc_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while a request is still in work");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_LIT || opcode == OP_COLOUR)) |=> busy)
    else $error("lookup request not taken into work");

  // The one opcode above the colour lookup has no function.
  a_unused_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode > OP_COLOUR) |=> (!busy && !done))
    else $error("unused opcode started work");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done || !$past(done)))
    else $error("inconsistent end of request");

endmodule

bind palette_nearest_colour_search_core pnc_checker u_pnc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .opcode        (opcode),
  .done          (done),
  .nearest_entry (nearest_entry)
);

/* test/pnc_search_checker.sv */
// Checker for the palette nearest-colour search core: watches the request and
// result ports, predicts each lookup from its own palette copy and compares.
// Depends on pnc_pkg for the opcode type.
`timescale 1ns / 1ps

module pnc_search_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] entry_index,
  input  logic [6:0] light_level,
  input  logic [7:0] blue_value,
  input  logic [7:0] green_value,
  input  logic [7:0] red_value,
  input  logic       done,
  input  logic [7:0] nearest_entry,
  output int         pending_picks,
  output int         picks_seen,
  output int         mismatch_count
);
  import pnc_pkg::*;

  localparam int PALETTE_SIZE = 256;
  localparam longint COLOUR_LIMIT = 9999999;
  localparam longint LIT_LIMIT = 64'h7fffffff;

  logic [7:0] pal_blue [PALETTE_SIZE];
  logic [7:0] pal_green [PALETTE_SIZE];
  logic [7:0] pal_red [PALETTE_SIZE];
  logic [7:0] expected_picks[$];

  function automatic longint scaled(input logic [7:0] v, input logic [6:0] level);
    longint s;
    s = (longint'(v) * longint'(level)) / 64;
    return (s > 255) ? 255 : s;
  endfunction

  function automatic longint mag(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic logic [7:0] lit_pick(input logic [7:0] idx, input logic [6:0] level);
    longint b, g, r, db, dg, dr, sq_sum, best;
    logic [7:0] pick;
    b = scaled(pal_blue[idx], level);
    g = scaled(pal_green[idx], level);
    r = scaled(pal_red[idx], level);
    best = LIT_LIMIT;
    pick = '0;
    for (int e = 1; e < PALETTE_SIZE; e++) begin
      db = mag(b - pal_blue[e]) * 4;
      dg = mag(g - pal_green[e]) * 5;
      dr = mag(r - pal_red[e]) * 3;
      sq_sum = db * db + dg * dg + dr * dr;
      if (sq_sum < best) begin
        best = sq_sum;
        pick = 8'(e);
      end
    end
    return pick;
  endfunction

  function automatic logic [7:0] colour_pick(input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] r);
    longint db, dg, dr, sum, score, best;
    logic [7:0] pick;
    best = COLOUR_LIMIT;
    pick = '0;
    for (int e = 1; e < PALETTE_SIZE; e++) begin
      db = (longint'(pal_blue[e]) - longint'(b)) * 4;
      dg = (longint'(pal_green[e]) - longint'(g)) * 5;
      dr = (longint'(pal_red[e]) - longint'(r)) * 3;
      sum = db + dg + dr;
      score = sum * sum + db * db + dg * dg + dr * dr;
      if (score < best) begin
        best = score;
        pick = 8'(e);
      end
    end
    return pick;
  endfunction

  initial begin
    for (int e = 0; e < PALETTE_SIZE; e++) begin
      pal_blue[e] = '0;
      pal_green[e] = '0;
      pal_red[e] = '0;
    end
    mismatch_count = 0;
    picks_seen = 0;
  end

  assign pending_picks = expected_picks.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        picks_seen <= picks_seen + 1;
        if (expected_picks.size() == 0) begin
          $error("nearest_entry: no result expected, actual %0d", nearest_entry);
          mismatch_count <= mismatch_count + 1;
        end else if (expected_picks[0] !== nearest_entry) begin
          $error("nearest_entry: expected %0d, actual %0d", expected_picks[0], nearest_entry);
          mismatch_count <= mismatch_count + 1;
          void'(expected_picks.pop_front());
        end else begin
          void'(expected_picks.pop_front());
        end
      end
      if (start && !busy) begin
        case (op_t'(opcode))
          OP_LOAD: begin
            pal_blue[entry_index] = (entry_index == 0) ? 8'd0 : blue_value;
            pal_green[entry_index] = (entry_index == 0) ? 8'd0 : green_value;
            pal_red[entry_index] = (entry_index == 0) ? 8'd0 : red_value;
          end
          OP_LIT: expected_picks.push_back(lit_pick(entry_index, light_level));
          OP_COLOUR: expected_picks.push_back(colour_pick(blue_value, green_value, red_value));
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/tb_palette_nearest_colour_search_core.sv */
// Testbench top for the palette nearest-colour search core: drives requests
// and gives the verdict. Depends on pnc_pkg, the core and pnc_search_checker.
`timescale 1ns / 1ps

module tb_palette_nearest_colour_search_core;
  import pnc_pkg::*;

  // Opcode 3 has no name in the package; the core must drop it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1600;
  // Enough for one lit lookup: fetch pass, search pass and pipeline drain.
  localparam int DRAIN_CYCLES = 600;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] opcode = '0;
  logic [7:0] entry_index = '0;
  logic [6:0] light_level = '0;
  logic [7:0] blue_value = '0;
  logic [7:0] green_value = '0;
  logic [7:0] red_value = '0;
  logic       done;
  logic [7:0] nearest_entry;

  int pending_picks;
  int picks_seen;
  int mismatch_count;
  int loads_sent = 0;
  int lit_sent = 0;
  int colour_sent = 0;
  int unused_sent = 0;

  // Last colour loaded, so that some colour lookups hit a palette entry exactly.
  logic [7:0] last_blue = '0;
  logic [7:0] last_green = '0;
  logic [7:0] last_red = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  palette_nearest_colour_search_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .entry_index(entry_index), .light_level(light_level), .blue_value(blue_value),
    .green_value(green_value), .red_value(red_value), .done(done),
    .nearest_entry(nearest_entry)
  );

  pnc_search_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .entry_index(entry_index), .light_level(light_level), .blue_value(blue_value),
    .green_value(green_value), .red_value(red_value), .done(done),
    .nearest_entry(nearest_entry), .pending_picks(pending_picks),
    .picks_seen(picks_seen), .mismatch_count(mismatch_count)
  );

  // Presents one request and holds it until the core takes it. Start stays high
  // afterwards, so that back-to-back requests follow without a gap.
  task automatic send_request(input logic [1:0] op, input logic [7:0] idx,
                              input logic [6:0] level, input logic [7:0] b,
                              input logic [7:0] g, input logic [7:0] r);
    start <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    light_level <= level;
    blue_value <= b;
    green_value <= g;
    red_value <= r;
    do @(posedge clk); while (busy);
    case (op)
      OP_LOAD: begin
        loads_sent++;
        last_blue = b;
        last_green = g;
        last_red = r;
      end
      OP_LIT: lit_sent++;
      OP_COLOUR: colour_sent++;
      default: unused_sent++;
    endcase
  endtask

  // Drops start for a number of idle cycles.
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] channel_value();
    return ($urandom_range(0, 9) < 2) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                      : 8'($urandom);
  endfunction

  initial begin
    logic [1:0] op;
    int pick;
    bit near_loaded;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. On the all-black palette a white colour lookup scores above
    // the bound everywhere, so no entry qualifies and zero comes back.
    send_request(OP_COLOUR, 8'd0, 7'd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_COLOUR, 8'd0, 7'd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_LIT, 8'd0, 7'd64, 8'h00, 8'h00, 8'h00);
    // A load to entry 0 must store black whatever the channels say.
    send_request(OP_LOAD, 8'd0, 7'd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_LOAD, 8'd255, 7'd127, 8'hff, 8'hff, 8'hff);
    send_request(OP_LOAD, 8'd1, 7'd0, 8'h80, 8'h40, 8'h20);
    send_request(OP_LOAD, 8'd128, 7'd0, 8'h01, 8'hfe, 8'h7f);
    send_request(OP_LOAD, 8'd2, 7'd0, 8'h10, 8'h10, 8'h10);
    // Unused opcode: nothing stored, nothing returned.
    send_request(OP_UNUSED, 8'd3, 7'd127, 8'hff, 8'hff, 8'hff);
    send_request(OP_LIT, 8'd0, 7'd64, 8'hff, 8'hff, 8'hff);
    send_request(OP_LIT, 8'd1, 7'd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_LIT, 8'd1, 7'd64, 8'h00, 8'h00, 8'h00);
    send_request(OP_LIT, 8'd1, 7'd127, 8'h00, 8'h00, 8'h00);
    send_request(OP_LIT, 8'd255, 7'd32, 8'h00, 8'h00, 8'h00);
    send_request(OP_LIT, 8'd128, 7'd127, 8'h00, 8'h00, 8'h00);
    send_request(OP_COLOUR, 8'd0, 7'd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_COLOUR, 8'd0, 7'd0, 8'h80, 8'h40, 8'h20);
    send_request(OP_COLOUR, 8'd0, 7'd0, 8'h00, 8'hff, 8'h00);
    send_request(OP_COLOUR, 8'd0, 7'd0, 8'hff, 8'h00, 8'hff);
    idle_for(3);

    // Random part: mostly palette loads and lookups against a well-populated
    // palette, with some unused opcodes mixed in as noise.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 40) ? OP_LOAD : (pick < 65) ? OP_LIT : (pick < 95) ? OP_COLOUR : OP_UNUSED;
      near_loaded = ($urandom_range(0, 3) == 0);
      if (op == OP_COLOUR && near_loaded) begin
        send_request(op, 8'($urandom), 7'($urandom), last_blue, last_green, last_red);
      end else begin
        send_request(op, ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom),
                     7'($urandom_range(0, 127)), channel_value(), channel_value(),
                     channel_value());
      end
      // Let the core run dry once mid-way, with no request waiting. The clock steps
      // on first, so that the request just taken is already counted as pending.
      if (n == 800) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_picks != 0) @(posedge clk);
      end
      // A long stretch between items 400 and 700 runs without idle cycles.
      if ((n < 400 || n > 700) && $urandom_range(0, 99) < 22) begin
        idle_for($urandom_range(1, 12));
      end
    end
    start <= 1'b0;

    while (pending_picks != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d lit lookups, %0d colour lookups, %0d unused opcodes.",
             loads_sent, lit_sent, colour_sent, unused_sent);
    $display("%0d results were checked against the predicted entries.", picks_seen);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
